>>> src/lfe_pkg.sv
// Shared constants, widths and arithmetic helpers for the line item field extractor.
// No dependencies; imported by lineitem_field_extractor_core.
package lfe_pkg;

   // Number of fraction digits kept in the price (hundredths by default), range 0..6
   localparam int FRACTION_DIGITS = 2;

   localparam int CHAR_W  = 8;
   localparam int KEY_W   = 32;
   localparam int QTY_W   = 16;
   localparam int PRICE_W = 40;
   localparam int CNT_W   = 3;
   localparam int FRAC_W  = 3;
   localparam int DIGIT_W = 4;
   // mac result: acc*10 + digit never needs more than 4 extra bits
   localparam int MAC_W   = PRICE_W + 4;
   // width of 10^k for k up to FRACTION_DIGITS
   localparam int SCALE_W = $clog2(10 ** FRACTION_DIGITS + 1);
   localparam int PROD_W  = PRICE_W + SCALE_W;

   localparam logic [FRAC_W-1:0] FRAC_LIMIT = FRAC_W'(FRACTION_DIGITS);

   localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_PIPE = 8'h7C;
   localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

   // delimiter count at which each field's characters arrive
   localparam logic [CNT_W-1:0] FIELD_KEY   = 3'd1;
   localparam logic [CNT_W-1:0] FIELD_QTY   = 3'd4;
   localparam logic [CNT_W-1:0] FIELD_PRICE = 3'd5;

   localparam logic [PRICE_W-1:0] KEY_MAX   = PRICE_W'({KEY_W{1'b1}});
   localparam logic [PRICE_W-1:0] QTY_MAX   = PRICE_W'({QTY_W{1'b1}});
   localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

   // acc*10 + digit, clamped to sat_max
   function automatic logic [PRICE_W-1:0] sat_mac10(input logic [PRICE_W-1:0] acc,
                                                    input logic [DIGIT_W-1:0] digit,
                                                    input logic [PRICE_W-1:0] sat_max);
      logic [MAC_W-1:0] sum;
      sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + MAC_W'(digit);
      if (sum > MAC_W'(sat_max)) begin
         return sat_max;
      end
      return sum[PRICE_W-1:0];
   endfunction

   function automatic logic [SCALE_W-1:0] pow10(input logic [FRAC_W-1:0] k);
      logic [19:0] v;
      case (k)
         3'd0:    v = 20'd1;
         3'd1:    v = 20'd10;
         3'd2:    v = 20'd100;
         3'd3:    v = 20'd1000;
         3'd4:    v = 20'd10000;
         3'd5:    v = 20'd100000;
         3'd6:    v = 20'd1000000;
         default: v = 20'd1;
      endcase
      return v[SCALE_W-1:0];
   endfunction

   // scale the price by 10 for each fraction digit that never arrived, saturating
   function automatic logic [PRICE_W-1:0] pad_price(input logic [PRICE_W-1:0] p,
                                                    input logic [FRAC_W-1:0] seen);
      logic [PROD_W-1:0] prod;
      logic [FRAC_W-1:0] missing;
      missing = (seen < FRAC_LIMIT) ? FRAC_LIMIT - seen : '0;
      prod = PROD_W'(p) * PROD_W'(pow10(missing));
      if (prod > PROD_W'(PRICE_MAX)) begin
         return PRICE_MAX;
      end
      return prod[PRICE_W-1:0];
   endfunction

endpackage

>>> src/lineitem_field_extractor_core.sv
// Line item field extractor: parses a pipe-delimited record one byte per cycle while req_stall is low.
// Depends on lfe_pkg for constants and the saturating decimal helpers.
//
//   channel | direction | ports                                            | handshake
//   req     | in        | req_char_code, req_line_start                    | req_valid / req_stall
//   rsp     | out       | rsp_part_key, rsp_quantity, rsp_price_hundredths,| rsp_valid / rsp_stall
//           |           | rsp_error                                        |
//
// One item per cycle while req_stall is low; a result appears in the output register
// the cycle after the sixth delimiter (or an early NUL) is taken.
// The parse state registers sit in front of the mac-by-10 helpers (key, quantity, price) and one pad multiply.
// Synchronous active-high reset leaves the parser waiting for a line start.
// req_stall rises only while a result is held and rsp_stall is high.
module lineitem_field_extractor_core
   import lfe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic                req_line_start,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KEY_W-1:0]    rsp_part_key,
   output logic [QTY_W-1:0]    rsp_quantity,
   output logic [PRICE_W-1:0]  rsp_price_hundredths,
   output logic                rsp_error
);

   logic [CNT_W-1:0]   count_ff,    count_in;
   logic [KEY_W-1:0]   key_ff,      key_in;
   logic [QTY_W-1:0]   qty_ff,      qty_in;
   logic [PRICE_W-1:0] price_ff,    price_in;
   logic               frac_ff,     frac_in;
   logic [FRAC_W-1:0]  seen_ff,     seen_in;
   logic               done_ff,     done_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]   rsp_key_ff,   rsp_key_in;
   logic [QTY_W-1:0]   rsp_qty_ff,   rsp_qty_in;
   logic [PRICE_W-1:0] rsp_price_ff, rsp_price_in;
   logic               rsp_error_ff, rsp_error_in;

   logic               req_accept;
   logic               is_digit;
   logic [DIGIT_W-1:0] digit;
   logic               emit;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign is_digit = req_char_code inside {[CHAR_ZERO:CHAR_NINE]};
   assign digit    = is_digit ? DIGIT_W'(req_char_code - CHAR_ZERO) : '0;

   always_comb begin
      // a line start clears the record before the byte is parsed
      if (req_line_start) begin
         count_in = '0;
         key_in   = '0;
         qty_in   = '0;
         price_in = '0;
         frac_in  = 1'b0;
         seen_in  = '0;
         done_in  = 1'b0;
      end else begin
         count_in = count_ff;
         key_in   = key_ff;
         qty_in   = qty_ff;
         price_in = price_ff;
         frac_in  = frac_ff;
         seen_in  = seen_ff;
         done_in  = done_ff;
      end

      emit         = 1'b0;
      rsp_key_in   = key_in;
      rsp_qty_in   = qty_in;
      rsp_price_in = pad_price(price_in, seen_in);
      rsp_error_in = 1'b0;

      if (!done_in) begin
         if (req_char_code == CHAR_NUL) begin
            emit         = 1'b1;
            rsp_key_in   = '0;
            rsp_qty_in   = '0;
            rsp_price_in = '0;
            rsp_error_in = 1'b1;
            done_in      = 1'b1;
         end else if (req_char_code == CHAR_PIPE) begin
            if (count_in >= FIELD_PRICE) begin
               emit    = 1'b1;
               done_in = 1'b1;
            end else begin
               count_in = count_in + 1'b1;
            end
         end else begin
            case (count_in)
               FIELD_KEY: begin
                  if (is_digit) begin
                     key_in = KEY_W'(sat_mac10(PRICE_W'(key_in), digit, KEY_MAX));
                  end
               end
               FIELD_QTY: begin
                  if (is_digit) begin
                     qty_in = QTY_W'(sat_mac10(PRICE_W'(qty_in), digit, QTY_MAX));
                  end
               end
               FIELD_PRICE: begin
                  if (req_char_code == CHAR_DOT) begin
                     frac_in = 1'b1;
                  end else if (is_digit) begin
                     if (!frac_in) begin
                        price_in = sat_mac10(price_in, digit, PRICE_MAX);
                     end else if (seen_in < FRAC_LIMIT) begin
                        price_in = sat_mac10(price_in, digit, PRICE_MAX);
                        seen_in  = seen_in + 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      if (req_accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         key_ff       <= '0;
         qty_ff       <= '0;
         price_ff     <= '0;
         frac_ff      <= 1'b0;
         seen_ff      <= '0;
         done_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            count_ff <= count_in;
            key_ff   <= key_in;
            qty_ff   <= qty_in;
            price_ff <= price_in;
            frac_ff  <= frac_in;
            seen_ff  <= seen_in;
            done_ff  <= done_in;
         end
      end
   end

   // result payload; only loaded when an item produces a result
   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_key_ff   <= rsp_key_in;
         rsp_qty_ff   <= rsp_qty_in;
         rsp_price_ff <= rsp_price_in;
         rsp_error_ff <= rsp_error_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_part_key         = rsp_key_ff;
   assign rsp_quantity         = rsp_qty_ff;
   assign rsp_price_hundredths = rsp_price_ff;
   assign rsp_error            = rsp_error_ff;

endmodule

>>> bench/lineitem_field_extractor_core_test.sv
// Self-checking bench for lineitem_field_extractor_core: directed records, then random records.
// Depends on lfe_pkg and the core; expected results come from an in-bench parser model or hand-written script rows.
module lineitem_field_extractor_core_test;
   import lfe_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [KEY_W-1:0]   part_key;
      logic [QTY_W-1:0]   quantity;
      logic [PRICE_W-1:0] price;
      logic               error;
   } extract_type;

   typedef struct packed {
      bit                typed;
      logic              start;
      logic [CHAR_W-1:0] ch;
      extract_type       want;
   } script_row_type;

   localparam extract_type NO_RESULT = '0;

   // typed rows carry a hand-written result; others are checked against the parser model
   localparam script_row_type SCRIPT [0:23] = '{
      '{1'b0, 1'b0, "A",       NO_RESULT},            // ignored, no line start yet
      '{1'b0, 1'b0, 8'hFF,     NO_RESULT},
      '{1'b1, 1'b1, CHAR_NUL,  '{32'd0, 16'd0, 40'd0, 1'b1}},
      '{1'b0, 1'b1, CHAR_PIPE, NO_RESULT},            // record opens on a delimiter
      '{1'b0, 1'b0, "9",       NO_RESULT},
      '{1'b0, 1'b0, 8'hFF,     NO_RESULT},            // junk inside the key
      '{1'b0, 1'b0, "8",       NO_RESULT},
      '{1'b0, 1'b0, CHAR_PIPE, NO_RESULT},
      '{1'b0, 1'b0, "4",       NO_RESULT},            // digit in an unused field
      '{1'b0, 1'b0, CHAR_PIPE, NO_RESULT},
      '{1'b0, 1'b0, CHAR_PIPE, NO_RESULT},
      '{1'b0, 1'b0, "7",       NO_RESULT},
      '{1'b0, 1'b0, CHAR_PIPE, NO_RESULT},
      '{1'b0, 1'b0, "1",       NO_RESULT},
      '{1'b0, 1'b0, CHAR_DOT,  NO_RESULT},
      '{1'b0, 1'b0, "5",       NO_RESULT},
      '{1'b0, 1'b0, CHAR_DOT,  NO_RESULT},            // second point is ignored
      '{1'b0, 1'b0, "8",       NO_RESULT},
      '{1'b0, 1'b0, "6",       NO_RESULT},            // third fraction digit dropped
      '{1'b1, 1'b0, CHAR_PIPE, '{32'd98, 16'd7, 40'd158, 1'b0}},
      '{1'b0, 1'b0, CHAR_NUL,  NO_RESULT},            // record done, NUL ignored
      '{1'b0, 1'b0, 8'hFF,     NO_RESULT},
      '{1'b0, 1'b1, "3",       NO_RESULT},            // digit before the first delimiter
      '{1'b1, 1'b0, CHAR_NUL,  '{32'd0, 16'd0, 40'd0, 1'b1}}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CHAR_W-1:0]   req_char_code = '0;
   logic                req_line_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [KEY_W-1:0]    rsp_part_key;
   logic [QTY_W-1:0]    rsp_quantity;
   logic [PRICE_W-1:0]  rsp_price_hundredths;
   logic                rsp_error;

   // parser model state
   logic [CNT_W-1:0]   pipes_seen = '0;
   logic [KEY_W-1:0]   key_sum = '0;
   logic [QTY_W-1:0]   qty_sum = '0;
   logic [PRICE_W-1:0] price_sum = '0;
   logic               after_point = 1'b0;
   logic [FRAC_W-1:0]  point_digits = '0;
   logic               waiting_start = 1'b1;

   extract_type pending_extracts [$];
   extract_type seen_extract;
   int          mismatches = 0;
   int          chars_sent = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   lineitem_field_extractor_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_char_code        (req_char_code),
      .req_line_start       (req_line_start),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_part_key         (rsp_part_key),
      .rsp_quantity         (rsp_quantity),
      .rsp_price_hundredths (rsp_price_hundredths),
      .rsp_error            (rsp_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [PRICE_W-1:0] times10_plus(input logic [PRICE_W-1:0] acc,
                                                       input logic [DIGIT_W-1:0] digit,
                                                       input logic [PRICE_W-1:0] ceiling);
      logic [63:0] v;
      v = 64'(acc) * 64'd10 + 64'(digit);
      return (v > 64'(ceiling)) ? ceiling : v[PRICE_W-1:0];
   endfunction

   // one character through the parser model; returns 1 when it closes a record
   function automatic bit parse_record_char(input logic [CHAR_W-1:0] c, input logic s,
                                            output extract_type r);
      logic               is_digit;
      logic [DIGIT_W-1:0] d;
      logic [PRICE_W-1:0] padded;
      int                 k;
      r = '0;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d = is_digit ? DIGIT_W'(c - CHAR_ZERO) : '0;
      if (s) begin
         pipes_seen = '0;
         key_sum = '0;
         qty_sum = '0;
         price_sum = '0;
         after_point = 1'b0;
         point_digits = '0;
         waiting_start = 1'b0;
      end
      if (waiting_start) return 1'b0;
      if (c == CHAR_NUL) begin
         r.error = 1'b1;
         waiting_start = 1'b1;
         return 1'b1;
      end
      if (c == CHAR_PIPE) begin
         if (pipes_seen >= FIELD_PRICE) begin
            padded = price_sum;
            for (k = int'(point_digits); k < FRACTION_DIGITS; k++) begin
               padded = times10_plus(padded, '0, PRICE_MAX);
            end
            r.part_key = key_sum;
            r.quantity = qty_sum;
            r.price = padded;
            waiting_start = 1'b1;
            return 1'b1;
         end
         pipes_seen = pipes_seen + 1'b1;
         return 1'b0;
      end
      if (pipes_seen == FIELD_KEY) begin
         if (is_digit) key_sum = KEY_W'(times10_plus(PRICE_W'(key_sum), d, KEY_MAX));
      end else if (pipes_seen == FIELD_QTY) begin
         if (is_digit) qty_sum = QTY_W'(times10_plus(PRICE_W'(qty_sum), d, QTY_MAX));
      end else if (pipes_seen == FIELD_PRICE) begin
         if (c == CHAR_DOT) begin
            after_point = 1'b1;
         end else if (is_digit) begin
            if (!after_point) begin
               price_sum = times10_plus(price_sum, d, PRICE_MAX);
            end else if (point_digits < FRAC_LIMIT) begin
               price_sum = times10_plus(price_sum, d, PRICE_MAX);
               point_digits = point_digits + 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // present one character, wait for it to be taken, then queue what it should produce
   task automatic feed_char(input logic [CHAR_W-1:0] c, input logic s, input bit typed,
                            input extract_type want);
      extract_type predicted;
      bit          closes;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_line_start <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
      closes = parse_record_char(c, s, predicted);
      if (typed) begin
         pending_extracts.push_back(want);
      end else if (closes) begin
         pending_extracts.push_back(predicted);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_extracts.size() != 0) @(posedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] rand_digit();
      return CHAR_ZERO + CHAR_W'($urandom_range(9));
   endfunction

   // any byte that is neither NUL nor a delimiter
   function automatic logic [CHAR_W-1:0] rand_filler();
      logic [CHAR_W-1:0] c;
      do c = CHAR_W'($urandom_range(1, 255)); while (c == CHAR_PIPE);
      return c;
   endfunction

   // mostly short runs, sometimes long enough to saturate
   function automatic int run_length(input int longest);
      return ($urandom_range(9) < 2) ? $urandom_range(longest) : $urandom_range(4);
   endfunction

   task automatic push_number(ref logic [CHAR_W-1:0] line [$], input int len);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(11) == 0) line.push_back(rand_filler());
         line.push_back(rand_digit());
      end
   endtask

   task automatic send_record();
      logic [CHAR_W-1:0] line [$];
      int                shape;
      int                f;
      int                i;
      int                cut;
      shape = $urandom_range(99);
      repeat ($urandom_range(2)) line.push_back(rand_filler());
      for (f = 1; f <= 5; f++) begin
         line.push_back(CHAR_PIPE);
         if (f == int'(FIELD_KEY)) begin
            push_number(line, run_length(12));
         end else if (f == int'(FIELD_QTY)) begin
            push_number(line, run_length(7));
         end else if (f == int'(FIELD_PRICE)) begin
            push_number(line, run_length(15));
            if ($urandom_range(3) != 0) begin
               line.push_back(CHAR_DOT);
               push_number(line, $urandom_range(4));
               if ($urandom_range(7) == 0) begin
                  line.push_back(CHAR_DOT);
                  push_number(line, $urandom_range(2));
               end
            end
         end else begin
            repeat ($urandom_range(3)) line.push_back(rand_filler());
         end
      end
      line.push_back(CHAR_PIPE);
      // bytes after the record closes are ignored until the next line start
      repeat ($urandom_range(3)) line.push_back(CHAR_W'($urandom_range(255)));
      if (shape < 8) begin
         line[$urandom_range(1, line.size() - 1)] = CHAR_NUL;
      end else if (shape < 14) begin
         cut = $urandom_range(1, line.size());
         while (line.size() > cut) void'(line.pop_back());
      end else if (shape < 18) begin
         line.delete();
         repeat ($urandom_range(1, 20)) line.push_back(CHAR_W'($urandom_range(255)));
      end
      for (i = 0; i < line.size(); i++) begin
         feed_char(line[i], (i == 0), 1'b0, NO_RESULT);
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_extracts.size() == 0) begin
            report_mismatch("result with none expected");
         end else begin
            seen_extract = pending_extracts.pop_front();
            if (rsp_part_key !== seen_extract.part_key)
               report_mismatch($sformatf("part_key %0d, expected %0d",
                                         rsp_part_key, seen_extract.part_key));
            if (rsp_quantity !== seen_extract.quantity)
               report_mismatch($sformatf("quantity %0d, expected %0d",
                                         rsp_quantity, seen_extract.quantity));
            if (rsp_price_hundredths !== seen_extract.price)
               report_mismatch($sformatf("price_hundredths %0d, expected %0d",
                                         rsp_price_hundredths, seen_extract.price));
            if (rsp_error !== seen_extract.error)
               report_mismatch($sformatf("error %0b, expected %0b",
                                         rsp_error, seen_extract.error));
         end
      end
   end

   // watchdog: too long without any item moving on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int row;
      int phase;
      int mark;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (row = 0; row < $size(SCRIPT); row++) begin
         feed_char(SCRIPT[row].ch, SCRIPT[row].start, SCRIPT[row].typed, SCRIPT[row].want);
      end
      drain_results();
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 45 : 0;
         stall_pct = (phase == 0) ? 45 : (phase == 1) ? 8 : 0;
         mark = chars_sent;
         while (chars_sent - mark < 200) begin
            send_record();
         end
         // sender holds off here until every result is out
         drain_results();
      end
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
src/lfe_pkg.sv
src/lineitem_field_extractor_core.sv
bench/lineitem_field_extractor_core_test.sv
